// ===== rtl/core/bb3_pkg.sv =====
package bb3_pkg;

	// Register indexes on the configuration port
	localparam logic CFG_IDX_WIDTH  = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;

	localparam int SUM_W   = 12;
	localparam int CNT_W   = 4;
	localparam int NUM_W   = 13;
	localparam int RECIP_W = 20;
	localparam int PROD_W  = NUM_W + RECIP_W;
	localparam int WIN_SIDE = 3;

	typedef struct packed {
		logic       cmd;
		logic [7:0] in_blue;
		logic [7:0] in_green;
		logic [7:0] in_red;
	} item_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic       frame_last;
	} result_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	typedef struct packed {
		pix_t upper;
		pix_t middle;
	} line_pair_t;

	// Window sums waiting for the divide
	typedef struct packed {
		logic [SUM_W-1:0] sum_blue;
		logic [SUM_W-1:0] sum_green;
		logic [SUM_W-1:0] sum_red;
		logic [CNT_W-1:0] count;
		logic             last;
	} acc_t;

	// ceil(2^20 / (2*count)): exact floor division for numerators below 2^13
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] c);
		logic [RECIP_W-1:0] m;
		case (c)
			4'd1: m = 20'd524288;
			4'd2: m = 20'd262144;
			4'd3: m = 20'd174763;
			4'd4: m = 20'd131072;
			4'd6: m = 20'd87382;
			4'd9: m = 20'd58255;
			default: m = 20'd524288;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/core/bb3_ram.sv =====
module bb3_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/bb3_fifo.sv =====
module bb3_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_pop;

	assign empty  = (count_q == '0);
	assign count  = count_q;
	assign rdata  = mem_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	// Store the incoming transaction
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(do_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CW'(DEPTH)) || do_pop)
		else $error("fifo overflow");

endmodule

// ===== rtl/core/bb3_front.sv =====
module bb3_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int QDEPTH     = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  bb3_pkg::item_t                    item,
	output logic                              full,
	input  logic                              restart,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]    img_w,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]   img_h,
	input  logic [$clog2(QDEPTH+1)-1:0]       q_count,
	output logic                              q_push,
	output bb3_pkg::acc_t                     q_data
);
	import bb3_pkg::*;

	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int RW  = $clog2(MAX_HEIGHT + 2);
	localparam int QCW = $clog2(QDEPTH + 1);

	logic [CW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;
	logic [CW-1:0] in_col_d, out_col_d;
	logic [RW-1:0] in_row_d, out_row_d;

	logic          accept, drain, take, emit, last;
	logic [2:0]    row_ok, col_ok;
	logic [1:0]    n_rows, n_cols;
	logic [CNT_W-1:0] count;
	pix_t          pix;

	logic          valid_s1, emit_s1, last_s1, fwd_s1;
	logic [CW-1:0] addr_s1;
	pix_t          pix_s1;
	logic [2:0]    row_ok_s1, col_ok_s1;
	logic [CNT_W-1:0] count_s1;
	line_pair_t    fwd_q;
	line_pair_t    ram_rd, lines, wr_pair;
	pix_t          win_q [WIN_SIDE*WIN_SIDE];
	pix_t          win_d [WIN_SIDE*WIN_SIDE];

	// Hold off while the queue cannot take every item in flight
	assign full   = ({1'b0, q_count} + (QCW+1)'(valid_s1)) >= (QCW+1)'(QDEPTH);
	assign accept = push && !full;
	assign drain  = (RW+1)'(in_row_q) >= (RW+1)'(img_h);
	// Drop a drain tick that comes before the frame is complete
	assign take   = accept && (drain || !item.cmd);
	assign emit   = (in_row_q >= 2) || (in_row_q == 1 && in_col_q != '0);

	assign pix.blue  = drain ? 8'd0 : item.in_blue;
	assign pix.green = drain ? 8'd0 : item.in_green;
	assign pix.red   = drain ? 8'd0 : item.in_red;

	// Classify neighbours of the output pixel as inside or outside the image
	always_comb begin
		row_ok[0] = (out_row_q != '0);
		row_ok[1] = (RW+1)'(out_row_q) < (RW+1)'(img_h);
		row_ok[2] = (RW+1)'(out_row_q) + 1'b1 < (RW+1)'(img_h);
		col_ok[0] = (out_col_q != '0);
		col_ok[1] = (WW+1)'(out_col_q) < (WW+1)'(img_w);
		col_ok[2] = (WW+1)'(out_col_q) + 1'b1 < (WW+1)'(img_w);
		n_rows = 2'(row_ok[0]) + 2'(row_ok[1]) + 2'(row_ok[2]);
		n_cols = 2'(col_ok[0]) + 2'(col_ok[1]) + 2'(col_ok[2]);
		count  = CNT_W'(n_rows) * CNT_W'(n_cols);
		if (count == '0) begin
			count = CNT_W'(1);
		end
		last = ((RW+1)'(out_row_q) + 1'b1 == (RW+1)'(img_h)) &&
			((WW+1)'(out_col_q) + 1'b1 == (WW+1)'(img_w));
	end

	// Advance the position counters
	always_comb begin
		in_col_d  = in_col_q;
		in_row_d  = in_row_q;
		out_col_d = out_col_q;
		out_row_d = out_row_q;
		if (take) begin
			if ((WW+1)'(in_col_q) + 1'b1 >= (WW+1)'(img_w)) begin
				in_col_d = '0;
				in_row_d = in_row_q + 1'b1;
			end else begin
				in_col_d = in_col_q + 1'b1;
			end
			if (emit) begin
				if ((WW+1)'(out_col_q) + 1'b1 >= (WW+1)'(img_w)) begin
					out_col_d = '0;
					out_row_d = out_row_q + 1'b1;
				end else begin
					out_col_d = out_col_q + 1'b1;
				end
			end
		end
		if (restart || (take && emit && last)) begin
			in_col_d  = '0;
			in_row_d  = '0;
			out_col_d = '0;
			out_row_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			in_col_q  <= in_col_d;
			in_row_q  <= in_row_d;
			out_col_q <= out_col_d;
			out_row_q <= out_row_d;
			valid_s1  <= take;
		end
	end

	// Capture the transaction for the line store stage
	always_ff @(posedge clk) begin
		if (take) begin
			addr_s1   <= in_col_q;
			pix_s1    <= pix;
			emit_s1   <= emit;
			last_s1   <= last;
			row_ok_s1 <= row_ok;
			col_ok_s1 <= col_ok;
			count_s1  <= count;
			fwd_s1    <= valid_s1 && (addr_s1 == in_col_q);
		end
		if (valid_s1) begin
			fwd_q <= wr_pair;
			for (int i = 0; i < WIN_SIDE*WIN_SIDE; i++) begin
				win_q[i] <= win_d[i];
			end
		end
	end

	bb3_ram #(
		.WIDTH ($bits(line_pair_t)),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (addr_s1),
		.wdata (wr_pair),
		.re    (take),
		.raddr (in_col_q),
		.rdata (ram_rd)
	);

	// Forward the pair written last cycle to a read of the same column
	assign lines          = fwd_s1 ? fwd_q : ram_rd;
	assign wr_pair.upper  = lines.middle;
	assign wr_pair.middle = pix_s1;

	// Shift the window one column
	always_comb begin
		for (int r = 0; r < WIN_SIDE; r++) begin
			win_d[r*WIN_SIDE]     = win_q[r*WIN_SIDE + 1];
			win_d[r*WIN_SIDE + 1] = win_q[r*WIN_SIDE + 2];
		end
		win_d[2] = lines.upper;
		win_d[5] = lines.middle;
		win_d[8] = pix_s1;
	end

	// Sum the in-image neighbours
	always_comb begin
		q_data.sum_blue  = '0;
		q_data.sum_green = '0;
		q_data.sum_red   = '0;
		for (int i = 0; i < WIN_SIDE*WIN_SIDE; i++) begin
			if (row_ok_s1[i / WIN_SIDE] && col_ok_s1[i % WIN_SIDE]) begin
				q_data.sum_blue  = q_data.sum_blue  + SUM_W'(win_d[i].blue);
				q_data.sum_green = q_data.sum_green + SUM_W'(win_d[i].green);
				q_data.sum_red   = q_data.sum_red   + SUM_W'(win_d[i].red);
			end
		end
		q_data.count = count_s1;
		q_data.last  = last_s1;
	end

	assign q_push = valid_s1 && emit_s1;

	a_fwd_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && fwd_s1) |-> $past(valid_s1))
		else $error("forwarding without a preceding write");

	a_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (count_s1 == 4'd1 || count_s1 == 4'd2 || count_s1 == 4'd3 ||
			count_s1 == 4'd4 || count_s1 == 4'd6 || count_s1 == 4'd9))
		else $error("illegal neighbour count");

endmodule

// ===== rtl/core/bb3_back.sv =====
module bb3_back #(
	parameter int OUT_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  bb3_pkg::acc_t     q_data,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output bb3_pkg::result_t  result
);
	import bb3_pkg::*;

	localparam int OCW = $clog2(OUT_DEPTH + 1);

	logic [OCW-1:0]     out_count;
	logic               valid_b1, last_b1;
	logic [PROD_W-1:0]  prod_b_b1, prod_g_b1, prod_r_b1;
	logic [RECIP_W-1:0] m;
	result_t            res;

	// Take from the queue only with room for what is in flight
	assign q_pop = !q_empty && (({1'b0, out_count} + (OCW+1)'(valid_b1)) <
		(OCW+1)'(OUT_DEPTH));
	assign m = recip(q_data.count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1 <= 1'b0;
		end else begin
			valid_b1 <= q_pop;
		end
	end

	// Multiply (2*sum + count) by the reciprocal of 2*count
	always_ff @(posedge clk) begin
		if (q_pop) begin
			prod_b_b1 <= PROD_W'({q_data.sum_blue, 1'b0} + NUM_W'(q_data.count)) *
				PROD_W'(m);
			prod_g_b1 <= PROD_W'({q_data.sum_green, 1'b0} + NUM_W'(q_data.count)) *
				PROD_W'(m);
			prod_r_b1 <= PROD_W'({q_data.sum_red, 1'b0} + NUM_W'(q_data.count)) *
				PROD_W'(m);
			last_b1   <= q_data.last;
		end
	end

	assign res.out_blue   = prod_b_b1[RECIP_W+7:RECIP_W];
	assign res.out_green  = prod_g_b1[RECIP_W+7:RECIP_W];
	assign res.out_red    = prod_r_b1[RECIP_W+7:RECIP_W];
	assign res.frame_last = last_b1;

	bb3_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (valid_b1),
		.wdata  (res),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty),
		.count  (out_count)
	);

	a_room_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_b1 |-> (out_count < OCW'(OUT_DEPTH)) || (pop && !empty))
		else $error("result pushed without room");

endmodule

// ===== rtl/core/box_blur_3x3_edge_aware_top.sv =====
// Output: a result passes the window stage, the sum queue, the multiply register and the result queue
// on its way to the result ports; its window completes one row plus one pixel after its own pixel.
// Throughput: one input transaction per cycle while full is low, set by the single line store
// memory with one read and one write port each cycle.
// Reset: arst_n clears counters, queues and pipeline valids; dimensions
// return to 1024 (or the maximum), line store contents are left as they are.
module box_blur_3x3_edge_aware_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  bb3_pkg::item_t     item,
	output logic               empty,
	input  logic               pop,
	output bb3_pkg::result_t   result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import bb3_pkg::*;

	localparam int WW      = $clog2(MAX_WIDTH + 1);
	localparam int HW      = $clog2(MAX_HEIGHT + 1);
	localparam int QDEPTH  = 4;
	localparam int QCW     = $clog2(QDEPTH + 1);
	localparam int W_RESET = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int H_RESET = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

	logic [WW-1:0]  width_q, width_d;
	logic [HW-1:0]  height_q, height_d;
	logic           cfg_wr;
	logic [10:0]    wval;
	logic [QCW-1:0] q_count;
	logic           q_push, q_pop, q_empty;
	acc_t           q_wdata, q_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign wval   = pwdata[10:0];

	// Clamp written dimensions into range
	always_comb begin
		width_d  = width_q;
		height_d = height_q;
		if (cfg_wr && paddr[2] == CFG_IDX_WIDTH) begin
			if (wval == '0) begin
				width_d = WW'(1);
			end else if (32'(wval) > MAX_WIDTH) begin
				width_d = WW'(MAX_WIDTH);
			end else begin
				width_d = WW'(wval);
			end
		end
		if (cfg_wr && paddr[2] == CFG_IDX_HEIGHT) begin
			if (wval == '0) begin
				height_d = HW'(1);
			end else if (32'(wval) > MAX_HEIGHT) begin
				height_d = HW'(MAX_HEIGHT);
			end else begin
				height_d = HW'(wval);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(W_RESET);
			height_q <= HW'(H_RESET);
		end else begin
			width_q  <= width_d;
			height_q <= height_d;
		end
	end

	assign prdata = (paddr[2] == CFG_IDX_HEIGHT) ? 32'(height_q) : 32'(width_q);

	bb3_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.QDEPTH     (QDEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.full    (full),
		.restart (cfg_wr),
		.img_w   (width_q),
		.img_h   (height_q),
		.q_count (q_count),
		.q_push  (q_push),
		.q_data  (q_wdata)
	);

	bb3_fifo #(
		.WIDTH ($bits(acc_t)),
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.count  (q_count)
	);

	bb3_back #(
		.OUT_DEPTH (4)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule
